>>> rtl/gbt_pkg.sv
// ----------------------------------------------------------------------------
// gbt_pkg
// Shared types, register indexes, datapath widths and saturation helpers for
// the gravity basin tracer.
// ----------------------------------------------------------------------------
package gbt_pkg;

  localparam int MAX_PLANETS_DEF = 4;
  localparam int COUNT_BITS_DEF  = 16;

  // Configuration register indexes
  localparam logic [2:0] REG_TIME_STEP   = 3'd0;
  localparam logic [2:0] REG_GRAVITY     = 3'd1;
  localparam logic [2:0] REG_ITER_LIMIT  = 3'd2;
  localparam logic [2:0] REG_PLANETS_USE = 3'd3;
  localparam logic [2:0] REG_PLANET0     = 3'd4;

  // Datapath widths
  localparam int D2_W   = 44;  // squared distance in Q.24
  localparam int ROOT_W = 22;  // distance in Q.12
  localparam int QUO_W  = 31;  // quotient bits (pull, component)
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 28;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [QUO_W-1:0] PULL_MAX = '1;

  typedef struct packed {
    logic signed [31:0] start_y;
    logic signed [31:0] start_x;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] step_count;
    logic        captured;
    logic [1:0]  planet_index;
  } out_beat_t;

  typedef struct packed {
    logic [15:0] radius;
    logic [15:0] mass;
    logic [15:0] y;
    logic [15:0] x;
  } planet_t;

  // Add a sign-magnitude term to a Q8.24 value and saturate to 32 bits.
  function automatic logic signed [31:0] add_sat(input logic signed [31:0] base,
                                                 input logic neg,
                                                 input logic [32:0] mag);
    logic signed [34:0] b;
    logic signed [34:0] t;
    logic signed [34:0] s;
    b = 35'(base);
    t = $signed({2'b00, mag});
    s = neg ? (b - t) : (b + t);
    if (s > 35'sh0_7FFF_FFFF) begin
      add_sat = 32'sh7FFF_FFFF;
    end else if (s < -35'sh0_8000_0000) begin
      add_sat = 32'sh8000_0000;
    end else begin
      add_sat = s[31:0];
    end
  endfunction

endpackage

>>> rtl/gbt_isqrt.sv
// ----------------------------------------------------------------------------
// gbt_isqrt
// Digit-by-digit integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module gbt_isqrt
  import gbt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [D2_W-1:0]   value,
  output logic [ROOT_W-1:0] root,
  output logic              busy
);

  localparam int CNT_W = $clog2(ROOT_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(ROOT_W - 1);

  logic [D2_W-1:0]   src_r;
  logic [ROOT_W+1:0] rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic [ROOT_W+3:0] sh;
  logic [ROOT_W+3:0] trial;

  assign sh    = {rem_r, src_r[D2_W-1 -: 2]};
  assign trial = {2'b00, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      src_r  <= value;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      src_r <= src_r << 2;
      if (sh >= trial) begin
        rem_r  <= (ROOT_W+2)'(sh - trial);
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= (ROOT_W+2)'(sh);
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign root = root_r;
  assign busy = busy_r;

endmodule

>>> rtl/gbt_div.sv
// ----------------------------------------------------------------------------
// gbt_div
// Restoring divider, one quotient bit per cycle, for a quotient known to fit.
// ----------------------------------------------------------------------------
module gbt_div
  import gbt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [D2_W-1:0]  rem_init,
  input  logic [QUO_W-1:0] num_lo,
  input  logic [D2_W-1:0]  divisor,
  output logic [QUO_W-1:0] quotient,
  output logic             done
);

  localparam int CNT_W = $clog2(QUO_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(QUO_W - 1);

  logic [D2_W-1:0]  rem_r;
  logic [D2_W-1:0]  dvs_r;
  logic [QUO_W-1:0] num_r;
  logic [QUO_W-1:0] q_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [D2_W:0]    sh;
  logic             fits;

  assign sh   = {rem_r, num_r[QUO_W-1]};
  assign fits = (sh >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      dvs_r <= divisor;
      num_r <= num_lo;
      q_r   <= '0;
    end else if (busy_r) begin
      num_r <= num_r << 1;
      q_r   <= {q_r[QUO_W-2:0], fits};
      if (fits) begin
        rem_r <= D2_W'(sh - {1'b0, dvs_r});
      end else begin
        rem_r <= sh[D2_W-1:0];
      end
    end
  end

  assign quotient = q_r;
  assign done     = done_r;

endmodule

>>> rtl/gravity_basin_tracer.sv
// ----------------------------------------------------------------------------
// gravity_basin_tracer
// Traces a particle released at rest through the field of up to four planets
// and reports which planet captures it, or that the step limit ran out.
// ----------------------------------------------------------------------------
// Usage:
//   Input: present start_x/start_y (Q8.24) on in_data and raise start while
//   busy is low; that edge takes the beat. busy stays high for the whole trace.
//   Output: out_valid strobes for exactly one cycle with out_data holding
//   planet_index, captured and step_count. The receiver cannot stall; take
//   the beat in that cycle. busy drops in the same cycle, so the next start
//   may come right away.
//   Configuration: write through cfg_we/cfg_index/cfg_data only while idle.
// Timing: a trace step is set by the shared restoring divider (up to three
//   divides per planet) with the square root running beside the first divide.
//   A trace runs up to iteration_limit steps; capture ends it early.
// Reset: synchronous, active low; configuration registers return to their defaults
//   (dt 655, G 256, limit 200, three planets, empty planet table).
// ----------------------------------------------------------------------------
module gravity_basin_tracer
  import gbt_pkg::*;
#(
  parameter int MAX_PLANETS = MAX_PLANETS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_beat_t    in_data,
  output logic        out_valid,
  output out_beat_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  // Sequencer state codes
  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_ITER    = 5'd1;
  localparam logic [4:0] S_CAP_X   = 5'd2;
  localparam logic [4:0] S_CAP_Y   = 5'd3;
  localparam logic [4:0] S_CAP_R   = 5'd4;
  localparam logic [4:0] S_CAP_C   = 5'd5;
  localparam logic [4:0] S_PULL_MX = 5'd6;
  localparam logic [4:0] S_PULL_MY = 5'd7;
  localparam logic [4:0] S_PULL_GM = 5'd8;
  localparam logic [4:0] S_PULL_CK = 5'd9;
  localparam logic [4:0] S_PULL_FW = 5'd10;
  localparam logic [4:0] S_PULL_FX = 5'd11;
  localparam logic [4:0] S_PULL_DX = 5'd12;
  localparam logic [4:0] S_PULL_WX = 5'd13;
  localparam logic [4:0] S_PULL_FY = 5'd14;
  localparam logic [4:0] S_PULL_DY = 5'd15;
  localparam logic [4:0] S_PULL_WY = 5'd16;
  localparam logic [4:0] S_UPD_VX  = 5'd17;
  localparam logic [4:0] S_UPD_VY  = 5'd18;
  localparam logic [4:0] S_UPD_PX  = 5'd19;
  localparam logic [4:0] S_UPD_PY  = 5'd20;
  localparam logic [4:0] S_UPD_END = 5'd21;

  localparam logic [COUNT_BITS-1:0] CNT_CAP = '1;

  // Configuration registers
  logic [15:0] time_step_r;
  logic [15:0] gravity_r;
  logic [15:0] iter_limit_r;
  logic [2:0]  planets_use_r;
  planet_t     planet_r [MAX_PLANETS];

  // Trace state
  logic [4:0]            state_r;
  logic signed [31:0]    px_r, py_r, vx_r, vy_r;
  logic signed [33:0]    ax_r, ay_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic [2:0]            pi_r;
  logic [56:0]           acc_r;
  logic [27:0]           dy_r;
  logic                  far_r;
  logic [20:0]           mx_r, my_r;
  logic                  sx_r, sy_r;
  logic                  sat_r;
  logic [QUO_W-1:0]      f_r;
  logic [PROD_W-1:0]     prod_r;
  logic                  out_valid_r;
  out_beat_t             out_data_r;

  // Combinational helpers
  planet_t               sel;
  logic [2:0]            n_act;
  logic [COUNT_BITS-1:0] limit;
  logic signed [31:0]    plx, ply;
  logic signed [32:0]    cdx, cdy, ex, ey;
  logic [32:0]           cdx_m, cdy_m, ex_m, ey_m;
  logic [MUL_A_W-1:0]    mul_a;
  logic [MUL_B_W-1:0]    mul_b;
  logic [33:0]           ax_m, ay_m;
  logic [31:0]           vx_m, vy_m;
  logic [2:0]            pi_inc;
  logic                  more;
  logic                  hit;
  logic [32:0]           term;

  // Shared divider and square root hookup
  logic              div_start;
  logic [D2_W-1:0]   div_rem0;
  logic [QUO_W-1:0]  div_lo;
  logic [D2_W-1:0]   div_dvs;
  logic [QUO_W-1:0]  div_q;
  logic              div_done;
  logic              sq_start;
  logic [ROOT_W-1:0] sq_root;
  logic              sq_busy;

  gbt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .rem_init (div_rem0),
    .num_lo   (div_lo),
    .divisor  (div_dvs),
    .quotient (div_q),
    .done     (div_done)
  );

  gbt_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .value (acc_r[D2_W-1:0]),
    .root  (sq_root),
    .busy  (sq_busy)
  );

  // Pick the current planet, clamp the active count and the step limit
  always_comb begin
    sel = planet_r[0];
    for (int j = 0; j < MAX_PLANETS; j++) begin
      if (32'(pi_r) == j) begin
        sel = planet_r[j];
      end
    end
    n_act = (32'(planets_use_r) > MAX_PLANETS) ? 3'(MAX_PLANETS) : planets_use_r;
    limit = (32'(iter_limit_r) > 32'(CNT_CAP)) ? CNT_CAP : COUNT_BITS'(iter_limit_r);
  end

  assign plx   = {{4{sel.x[15]}}, sel.x, 12'b0};
  assign ply   = {{4{sel.y[15]}}, sel.y, 12'b0};
  assign cdx   = 33'(px_r) - 33'(plx);
  assign cdy   = 33'(py_r) - 33'(ply);
  assign ex    = -cdx;
  assign ey    = -cdy;
  assign cdx_m = cdx[32] ? 33'(-cdx) : 33'(cdx);
  assign cdy_m = cdy[32] ? 33'(-cdy) : 33'(cdy);
  assign ex_m  = cdx_m;
  assign ey_m  = cdy_m;
  assign ax_m  = ax_r[33] ? 34'(-ax_r) : 34'(ax_r);
  assign ay_m  = ay_r[33] ? 34'(-ay_r) : 34'(ay_r);
  assign vx_m  = vx_r[31] ? 32'(-vx_r) : 32'(vx_r);
  assign vy_m  = vy_r[31] ? 32'(-vy_r) : 32'(vy_r);
  assign pi_inc = pi_r + 3'd1;
  assign more  = (pi_inc < n_act);
  assign hit   = !far_r && (acc_r < {1'b0, prod_r[31:0], 24'b0});
  assign term  = prod_r[48:16];

  // Operand select for the one shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_CAP_X: begin
        mul_a = MUL_A_W'(cdx_m[27:0]);
        mul_b = cdx_m[27:0];
      end
      S_CAP_Y: begin
        mul_a = MUL_A_W'(dy_r);
        mul_b = dy_r;
      end
      S_CAP_R: begin
        mul_a = MUL_A_W'(sel.radius);
        mul_b = MUL_B_W'(sel.radius);
      end
      S_PULL_MX: begin
        mul_a = MUL_A_W'(ex_m[32:12]);
        mul_b = MUL_B_W'(ex_m[32:12]);
      end
      S_PULL_MY: begin
        mul_a = MUL_A_W'(my_r);
        mul_b = MUL_B_W'(my_r);
      end
      S_PULL_GM: begin
        mul_a = MUL_A_W'(gravity_r);
        mul_b = MUL_B_W'(sel.mass);
      end
      S_PULL_FX: begin
        mul_a = MUL_A_W'(f_r);
        mul_b = MUL_B_W'(mx_r);
      end
      S_PULL_FY: begin
        mul_a = MUL_A_W'(f_r);
        mul_b = MUL_B_W'(my_r);
      end
      S_UPD_VX: begin
        mul_a = ax_m;
        mul_b = MUL_B_W'(time_step_r);
      end
      S_UPD_VY: begin
        mul_a = ay_m;
        mul_b = MUL_B_W'(time_step_r);
      end
      S_UPD_PX: begin
        mul_a = MUL_A_W'(vx_m);
        mul_b = MUL_B_W'(time_step_r);
      end
      S_UPD_PY: begin
        mul_a = MUL_A_W'(vy_m);
        mul_b = MUL_B_W'(time_step_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Divider and root launches
  always_comb begin
    div_start = 1'b0;
    sq_start  = 1'b0;
    div_rem0  = '0;
    div_lo    = '0;
    div_dvs   = acc_r[D2_W-1:0];
    case (state_r)
      S_PULL_CK: begin
        // pull = GM * 2^32 / d2; start the remainder at GM * 2
        div_start = (acc_r != '0);
        sq_start  = (acc_r != '0);
        div_rem0  = D2_W'({prod_r[31:0], 1'b0});
      end
      S_PULL_DX, S_PULL_DY: begin
        // component = pull * m / d
        div_start = 1'b1;
        div_rem0  = D2_W'(prod_r[51:QUO_W]);
        div_lo    = prod_r[QUO_W-1:0];
        div_dvs   = D2_W'(sq_root);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r   <= 16'd655;
      gravity_r     <= 16'd256;
      iter_limit_r  <= 16'd200;
      planets_use_r <= 3'd3;
      for (int j = 0; j < MAX_PLANETS; j++) begin
        planet_r[j] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIME_STEP:   time_step_r   <= cfg_data[15:0];
        REG_GRAVITY:     gravity_r     <= cfg_data[15:0];
        REG_ITER_LIMIT:  iter_limit_r  <= cfg_data[15:0];
        REG_PLANETS_USE: planets_use_r <= cfg_data[2:0];
        default: begin
          // drop planet words beyond the table
          for (int j = 0; j < MAX_PLANETS; j++) begin
            if (32'(cfg_index) == 32'(REG_PLANET0) + j) begin
              planet_r[j] <= cfg_data;
            end
          end
        end
      endcase
    end
  end

  // Multiplier output register
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Sequencer and trace datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            px_r    <= in_data.start_x;
            py_r    <= in_data.start_y;
            vx_r    <= '0;
            vy_r    <= '0;
            cnt_r   <= '0;
            state_r <= S_ITER;
          end
        end
        S_ITER: begin
          ax_r <= '0;
          ay_r <= '0;
          pi_r <= '0;
          if (cnt_r >= limit) begin
            out_valid_r             <= 1'b1;
            out_data_r.planet_index <= '0;
            out_data_r.captured     <= 1'b0;
            out_data_r.step_count   <= 16'(cnt_r);
            state_r                 <= S_IDLE;
          end else if (n_act == 3'd0) begin
            state_r <= S_UPD_VX;
          end else begin
            state_r <= S_CAP_X;
          end
        end
        S_CAP_X: begin
          far_r   <= (cdx_m[32:28] != '0) || (cdy_m[32:28] != '0);
          dy_r    <= cdy_m[27:0];
          state_r <= S_CAP_Y;
        end
        S_CAP_Y: begin
          acc_r   <= 57'(prod_r);
          state_r <= S_CAP_R;
        end
        S_CAP_R: begin
          acc_r   <= acc_r + 57'(prod_r);
          state_r <= S_CAP_C;
        end
        S_CAP_C: begin
          if (hit) begin
            out_valid_r             <= 1'b1;
            out_data_r.planet_index <= pi_r[1:0];
            out_data_r.captured     <= 1'b1;
            out_data_r.step_count   <= 16'(cnt_r);
            state_r                 <= S_IDLE;
          end else if (more) begin
            pi_r    <= pi_inc;
            state_r <= S_CAP_X;
          end else begin
            pi_r    <= '0;
            state_r <= S_PULL_MX;
          end
        end
        S_PULL_MX: begin
          mx_r    <= ex_m[32:12];
          my_r    <= ey_m[32:12];
          sx_r    <= ex[32];
          sy_r    <= ey[32];
          state_r <= S_PULL_MY;
        end
        S_PULL_MY: begin
          acc_r   <= 57'(prod_r);
          state_r <= S_PULL_GM;
        end
        S_PULL_GM: begin
          acc_r   <= acc_r + 57'(prod_r);
          state_r <= S_PULL_CK;
        end
        S_PULL_CK: begin
          // a particle on the centre feels no pull from that planet
          sat_r <= (57'({prod_r[31:0], 1'b0}) >= acc_r);
          if (acc_r != '0) begin
            state_r <= S_PULL_FW;
          end else if (more) begin
            pi_r    <= pi_inc;
            state_r <= S_PULL_MX;
          end else begin
            state_r <= S_UPD_VX;
          end
        end
        S_PULL_FW: begin
          if (div_done) begin
            f_r     <= sat_r ? PULL_MAX : div_q;
            state_r <= S_PULL_FX;
          end
        end
        S_PULL_FX: state_r <= S_PULL_DX;
        S_PULL_DX: state_r <= S_PULL_WX;
        S_PULL_WX: begin
          if (div_done) begin
            ax_r    <= sx_r ? (ax_r - 34'(div_q)) : (ax_r + 34'(div_q));
            state_r <= S_PULL_FY;
          end
        end
        S_PULL_FY: state_r <= S_PULL_DY;
        S_PULL_DY: state_r <= S_PULL_WY;
        S_PULL_WY: begin
          if (div_done) begin
            ay_r <= sy_r ? (ay_r - 34'(div_q)) : (ay_r + 34'(div_q));
            if (more) begin
              pi_r    <= pi_inc;
              state_r <= S_PULL_MX;
            end else begin
              state_r <= S_UPD_VX;
            end
          end
        end
        S_UPD_VX: state_r <= S_UPD_VY;
        S_UPD_VY: begin
          vx_r    <= add_sat(vx_r, ax_r[33], term);
          state_r <= S_UPD_PX;
        end
        S_UPD_PX: begin
          vy_r    <= add_sat(vy_r, ay_r[33], term);
          state_r <= S_UPD_PY;
        end
        S_UPD_PY: begin
          px_r    <= add_sat(px_r, vx_r[31], term);
          state_r <= S_UPD_END;
        end
        S_UPD_END: begin
          py_r    <= add_sat(py_r, vy_r[31], term);
          cnt_r   <= cnt_r + 1'b1;
          state_r <= S_ITER;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The root finishes before the pull divide it runs beside
  a_root_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PULL_FW && div_done) |-> !sq_busy)
    else $error("square root still busy when pull divide finished");

  // A result only closes a trace that was running
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a running trace");

  // An accepted start begins a trace
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("start accepted but tracer not busy");

  // Misses report planet zero
  a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.captured) |-> (out_data.planet_index == '0))
    else $error("miss reported with nonzero planet index");

endmodule
